// ===== rtl/stpc_pkg.sv =====
`default_nettype none

package stpc_pkg;

    localparam int unsigned DataW   = 16;
    localparam int unsigned CfgIdxW = 2;
    localparam int unsigned QuotW   = 30;
    localparam int unsigned OpndW   = 32;

    // Q0.15 full scale for throttle and brake, Q1.14 full scale for steer
    localparam logic [DataW-1:0] DemandFull = 16'd32768;
    localparam logic [DataW-1:0] SteerFull  = 16'd16384;

    localparam logic [DataW-1:0] SteerLimitRst   = 16'd4096;
    localparam logic [DataW-1:0] GainThrottleRst = 16'd2048;
    localparam logic [DataW-1:0] GainBrakeRst    = 16'd2048;

    typedef enum logic [1:0] {
        OP_ODOMETRY = 2'd0,
        OP_COMMAND  = 2'd1,
        OP_TICK     = 2'd2,
        OP_UNUSED   = 2'd3
    } opcode_t;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_STEER_LIMIT   = 2'd0,
        CFG_GAIN_THROTTLE = 2'd1,
        CFG_GAIN_BRAKE    = 2'd2,
        CFG_NONE          = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic [1:0]              opcode;
        logic signed [DataW-1:0] vel_x;
        logic signed [DataW-1:0] vel_y;
        logic signed [DataW-1:0] target_angle;
        logic signed [DataW-1:0] target_speed;
    } in_item_t;

    typedef struct packed {
        logic signed [DataW-1:0] steer_out;
        logic [DataW-1:0]        throttle_out;
        logic [DataW-1:0]        brake_out;
    } out_item_t;

    typedef struct packed {
        logic             start;
        logic             mode_sqrt;
        logic [OpndW-1:0] operand;
        logic [DataW-1:0] divisor;
    } sqdiv_req_t;

    typedef struct packed {
        logic             done;
        logic [QuotW-1:0] result;
    } sqdiv_stat_t;

endpackage

`default_nettype wire

// ===== rtl/steer_throttle_brake_p_controller_unit.sv =====
// Steering and throttle/brake demand generator.
// Input channel s_*: one request per accepted item, kind given by opcode.
//   odometry stores the signed speed magnitude, command stores the target
//   angle and speed, tick produces one result on m_*; opcode 3 is dropped.
// Configuration: cfg_wr_en writes cfg_wdata to register cfg_index at once
//   (0 steer limit, 1 throttle gain, 2 brake gain); other indexes are ignored.
// One item is worked on at a time and s_ready is low meanwhile. A shared
//   17x17 multiplier and one trial-subtract root/divide unit do the work:
//   a command is stored from the idle state, odometry takes 16 root steps
//   and a tick 30 divide steps; a tick skips the divide when the limit is
//   zero and goes straight to the output when no command has been seen yet.
// Results sit in an output register; a tick that finishes while the
//   previous result is still stalled waits in the out state until m_ready takes it.
// Reset (aresetn low, synchronous) clears stored speed, angle and command
//   flag, loads the register defaults and drops m_valid.
`default_nettype none

module steer_throttle_brake_p_controller_unit (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    cfg_wr_en,
    input  wire logic [1:0]              cfg_index,
    input  wire logic [15:0]             cfg_wdata,
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire stpc_pkg::in_item_t      s_data,
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output stpc_pkg::out_item_t          m_data
);
    import stpc_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ODO_MX,
        ST_ODO_MY,
        ST_ODO_GO,
        ST_ODO_ROOT,
        ST_TICK_MUL,
        ST_TICK_DEM,
        ST_TICK_DIV,
        ST_OUT
    } state_t;

    state_t state_reg;

    logic signed [DataW-1:0] limit_reg;
    logic [DataW-1:0]        gain_thr_reg;
    logic [DataW-1:0]        gain_brk_reg;
    logic signed [DataW-1:0] meas_reg;
    logic signed [DataW-1:0] angle_reg;
    logic signed [DataW-1:0] speed_reg;
    logic                    seen_reg;
    logic signed [DataW-1:0] vx_reg;
    logic signed [DataW-1:0] vy_reg;
    logic [31:0]             sum_reg;
    logic [31:0]             prod_reg;
    logic                    epos_reg;
    logic [DataW-1:0]        thr_reg;
    logic [DataW-1:0]        brk_reg;
    logic signed [DataW-1:0] steer_reg;
    logic                    m_valid_reg;
    out_item_t               m_data_reg;

    logic signed [16:0] mul_a;
    logic signed [16:0] mul_b;
    logic signed [33:0] mul_full;

    logic signed [16:0] err;
    logic [16:0]        err_neg;
    logic [DataW-1:0]   err_mag;
    logic               err_pos;
    logic [DataW-1:0]   angle_abs;
    logic [DataW-1:0]   limit_abs;
    logic               limit_zero;

    logic [26:0]        dem_raw;
    logic [DataW-1:0]   dem_sat;
    logic [16:0]        root;
    logic signed [DataW-1:0] speed_sat;
    logic [QuotW-1:0]   quot;
    logic [DataW-1:0]   steer_mag;
    logic signed [DataW-1:0] steer_val;

    sqdiv_req_t  sd_req;
    sqdiv_stat_t sd_stat;

    stpc_sqdiv u_sqdiv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (sd_req),
        .stat    (sd_stat)
    );

    always_comb begin
        err        = {speed_reg[DataW-1], speed_reg} - {meas_reg[DataW-1], meas_reg};
        err_neg    = 17'(-err);
        err_mag    = err[16] ? err_neg[DataW-1:0] : err[DataW-1:0];
        err_pos    = !err[16] && (err != '0);
        angle_abs  = angle_reg[DataW-1] ? DataW'(-angle_reg) : angle_reg;
        limit_abs  = limit_reg[DataW-1] ? DataW'(-limit_reg) : limit_reg;
        limit_zero = (limit_reg == '0);

        // shared multiplier operand select
        case (state_reg)
            ST_ODO_MX: begin
                mul_a = {vx_reg[DataW-1], vx_reg};
                mul_b = {vx_reg[DataW-1], vx_reg};
            end
            ST_ODO_MY: begin
                mul_a = {vy_reg[DataW-1], vy_reg};
                mul_b = {vy_reg[DataW-1], vy_reg};
            end
            ST_TICK_MUL: begin
                mul_a = {1'b0, err_pos ? gain_thr_reg : gain_brk_reg};
                mul_b = {1'b0, err_mag};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_full = mul_a * mul_b;

        sd_req.start     = 1'b0;
        sd_req.mode_sqrt = 1'b0;
        sd_req.operand   = {angle_abs[QuotW-15:0], 16'd0};
        sd_req.divisor   = limit_abs;
        if (state_reg == ST_ODO_GO) begin
            sd_req.start     = 1'b1;
            sd_req.mode_sqrt = 1'b1;
            sd_req.operand   = sum_reg + prod_reg;
        end else if (state_reg == ST_TICK_MUL) begin
            sd_req.start = !limit_zero;
        end

        dem_raw = prod_reg[31:5];
        dem_sat = (dem_raw > 27'(DemandFull)) ? DemandFull : dem_raw[DataW-1:0];

        // signed speed, saturated to the Q7.8 range
        root = {1'b0, sd_stat.result[DataW-1:0]};
        if (vx_reg[DataW-1]) begin
            speed_sat = (root > 17'd32768) ? 16'sh8000 : DataW'(-root);
        end else begin
            speed_sat = (root > 17'd32767) ? 16'sh7fff : root[DataW-1:0];
        end

        quot      = sd_stat.result;
        steer_mag = (quot > QuotW'(SteerFull)) ? SteerFull : quot[DataW-1:0];
        steer_val = (angle_reg[DataW-1] ^ limit_reg[DataW-1]) ? DataW'(-steer_mag)
                                                                : steer_mag;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            limit_reg    <= SteerLimitRst;
            gain_thr_reg <= GainThrottleRst;
            gain_brk_reg <= GainBrakeRst;
            meas_reg     <= '0;
            angle_reg    <= '0;
            speed_reg    <= '0;
            seen_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_STEER_LIMIT:   limit_reg    <= cfg_wdata;
                    CFG_GAIN_THROTTLE: gain_thr_reg <= cfg_wdata;
                    CFG_GAIN_BRAKE:    gain_brk_reg <= cfg_wdata;
                    default: ;
                endcase
            end

            prod_reg <= mul_full[31:0];
            // in ST_OUT the output register is handled below
            if (m_valid_reg && m_ready && (state_reg != ST_OUT)) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        vx_reg <= s_data.vel_x;
                        vy_reg <= s_data.vel_y;
                        case (s_data.opcode)
                            OP_ODOMETRY: state_reg <= ST_ODO_MX;
                            OP_COMMAND: begin
                                angle_reg <= s_data.target_angle;
                                speed_reg <= s_data.target_speed;
                                seen_reg  <= 1'b1;
                            end
                            OP_TICK: begin
                                if (seen_reg) begin
                                    state_reg <= ST_TICK_MUL;
                                end else begin
                                    steer_reg <= '0;
                                    thr_reg   <= '0;
                                    brk_reg   <= '0;
                                    state_reg <= ST_OUT;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                ST_ODO_MX: state_reg <= ST_ODO_MY;
                ST_ODO_MY: begin
                    sum_reg   <= prod_reg;
                    state_reg <= ST_ODO_GO;
                end
                ST_ODO_GO: state_reg <= ST_ODO_ROOT;
                ST_ODO_ROOT: begin
                    if (sd_stat.done) begin
                        meas_reg  <= speed_sat;
                        state_reg <= ST_IDLE;
                    end
                end
                ST_TICK_MUL: begin
                    epos_reg  <= err_pos;
                    state_reg <= ST_TICK_DEM;
                end
                ST_TICK_DEM: begin
                    thr_reg <= epos_reg ? dem_sat : '0;
                    brk_reg <= epos_reg ? '0 : dem_sat;
                    if (limit_zero) begin
                        steer_reg <= '0;
                        state_reg <= ST_OUT;
                    end else begin
                        state_reg <= ST_TICK_DIV;
                    end
                end
                ST_TICK_DIV: begin
                    if (sd_stat.done) begin
                        steer_reg <= steer_val;
                        state_reg <= ST_OUT;
                    end
                end
                ST_OUT: begin
                    // hold until the previous result has been taken
                    if (!m_valid_reg || m_ready) begin
                        m_data_reg.steer_out    <= steer_reg;
                        m_data_reg.throttle_out <= thr_reg;
                        m_data_reg.brake_out    <= brk_reg;
                        m_valid_reg             <= 1'b1;
                        state_reg               <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

// ===== rtl/stpc_sqdiv.sv =====
`default_nettype none

module stpc_sqdiv (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire stpc_pkg::sqdiv_req_t  req,
    output stpc_pkg::sqdiv_stat_t      stat
);
    import stpc_pkg::*;

    localparam int unsigned RemW = 19;
    localparam logic [4:0] SqrtSteps = 5'd16;
    localparam logic [4:0] DivSteps  = 5'(QuotW);

    logic [OpndW-1:0] opnd_reg;
    logic [RemW-1:0]  rem_reg;
    logic [QuotW-1:0] res_reg;
    logic [DataW-1:0] dvsr_reg;
    logic             sqrt_reg;
    logic [4:0]       cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [RemW-1:0]  rem_sh;
    logic [RemW-1:0]  trial;
    logic             take;

    // one trial subtract per cycle: two radicand bits for the root, one for the quotient
    always_comb begin
        if (sqrt_reg) begin
            rem_sh = {rem_reg[RemW-3:0], opnd_reg[OpndW-1 -: 2]};
            trial  = {res_reg[RemW-3:0], 2'b01};
        end else begin
            rem_sh = {rem_reg[RemW-2:0], opnd_reg[OpndW-1]};
            trial  = {3'b000, dvsr_reg};
        end
        take = (rem_sh >= trial);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && !req.start && (cnt_reg == 5'd1);
            if (req.start) begin
                opnd_reg <= req.operand;
                dvsr_reg <= req.divisor;
                sqrt_reg <= req.mode_sqrt;
                rem_reg  <= '0;
                res_reg  <= '0;
                cnt_reg  <= req.mode_sqrt ? SqrtSteps : DivSteps;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rem_reg  <= take ? (rem_sh - trial) : rem_sh;
                res_reg  <= {res_reg[QuotW-2:0], take};
                opnd_reg <= sqrt_reg ? {opnd_reg[OpndW-3:0], 2'b00}
                                     : {opnd_reg[OpndW-2:0], 1'b0};
                cnt_reg  <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd1) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    assign stat.done   = done_reg;
    assign stat.result = res_reg;

endmodule

`default_nettype wire

// ===== bench/testbench.sv =====
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import stpc_pkg::*;

    localparam int LIMIT_CYCLES  = 500000;
    // leave margin for a tick or odometry still in flight before touching registers
    localparam int SETTLE_CYCLES = 64;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_wr_en;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    in_item_t    s_data;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_item_t   m_data;

    bit steady = 1'b0;
    int n_cycles   = 0;
    int n_errors   = 0;
    int n_requests = 0;
    int n_results  = 0;
    int n_settings = 0;

    // controller state as the bench sees it
    logic signed [15:0] steer_limit_q;
    logic [15:0]        gain_thr_q;
    logic [15:0]        gain_brk_q;
    logic signed [15:0] speed_meas_q;
    logic signed [15:0] angle_cmd_q;
    logic signed [15:0] speed_cmd_q;
    bit                 cmd_seen_q;

    out_item_t expected_demands[$];

    steer_throttle_brake_p_controller_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        n_cycles++;
        if (n_cycles > LIMIT_CYCLES) begin
            $display("status: fail");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_ready <= steady || ($urandom_range(99) >= 9);
    end

    function automatic logic [15:0] root_of(longint unsigned n);
        logic [15:0] r;
        logic [15:0] trial;
        r = '0;
        for (int b = 15; b >= 0; b--) begin
            trial = r | (16'd1 << b);
            if (longint'(trial) * longint'(trial) <= n)
                r = trial;
        end
        return r;
    endfunction

    function automatic logic signed [15:0] signed_speed(logic signed [15:0] vx,
                                                        logic signed [15:0] vy);
        longint sq;
        longint mag;
        sq  = longint'(vx) * longint'(vx) + longint'(vy) * longint'(vy);
        mag = longint'(root_of(sq));
        // sign follows the forward component only
        if (vx < 0)
            mag = -mag;
        if (mag > 32767)
            mag = 32767;
        if (mag < -32768)
            mag = -32768;
        return mag[15:0];
    endfunction

    function automatic logic [15:0] scaled_demand(logic [15:0] gain, longint err);
        longint p;
        // q4.12 times q7.8 down to q0.15
        p = (longint'(gain) * err) >>> 5;
        return (p > longint'(DemandFull)) ? DemandFull : p[15:0];
    endfunction

    function automatic out_item_t tick_result();
        out_item_t r;
        longint    q;
        longint    err;
        r = '0;
        if (!cmd_seen_q)
            return r;
        if (steer_limit_q != 0) begin
            q = (longint'(angle_cmd_q) * longint'(SteerFull)) / longint'(steer_limit_q);
            if (q > longint'(SteerFull))
                q = longint'(SteerFull);
            if (q < -longint'(SteerFull))
                q = -longint'(SteerFull);
            r.steer_out = q[15:0];
        end
        err = longint'(speed_cmd_q) - longint'(speed_meas_q);
        if (err > 0)
            r.throttle_out = scaled_demand(gain_thr_q, err);
        else
            r.brake_out = scaled_demand(gain_brk_q, -err);
        return r;
    endfunction

    task automatic absorb_request(in_item_t req);
        case (opcode_t'(req.opcode))
            OP_ODOMETRY: speed_meas_q = signed_speed(req.vel_x, req.vel_y);
            OP_COMMAND: begin
                angle_cmd_q = req.target_angle;
                speed_cmd_q = req.target_speed;
                cmd_seen_q  = 1'b1;
            end
            OP_TICK: expected_demands.push_back(tick_result());
            default: ;
        endcase
    endtask

    function automatic in_item_t noise_req(opcode_t op);
        in_item_t r;
        logic [31:0] a;
        logic [31:0] b;
        a = $urandom;
        b = $urandom;
        r.opcode       = op;
        r.vel_x        = a[15:0];
        r.vel_y        = a[31:16];
        r.target_angle = b[15:0];
        r.target_speed = b[31:16];
        return r;
    endfunction

    function automatic in_item_t odometry_req(logic [15:0] vx, logic [15:0] vy);
        in_item_t r;
        r = noise_req(OP_ODOMETRY);
        r.vel_x = vx;
        r.vel_y = vy;
        return r;
    endfunction

    function automatic in_item_t command_req(logic [15:0] angle, logic [15:0] speed);
        in_item_t r;
        r = noise_req(OP_COMMAND);
        r.target_angle = angle;
        r.target_speed = speed;
        return r;
    endfunction

    function automatic logic [15:0] pick_value();
        int v;
        case ($urandom_range(9))
            0, 1, 2, 3: v = $urandom;
            4, 5, 6: v = int'($urandom_range(2047)) - 1024;
            7: v = int'($urandom_range(16383)) - 8192;
            default: begin
                case ($urandom_range(3))
                    0: v = -32768;
                    1: v = 32767;
                    2: v = 0;
                    default: v = -1;
                endcase
            end
        endcase
        return v[15:0];
    endfunction

    function automatic logic [15:0] pick_limit();
        int v;
        case ($urandom_range(7))
            0: v = 0;
            1: v = -32768;
            2: v = 32767;
            3: v = 1;
            4: v = -1;
            5: v = 4096;
            default: v = $urandom;
        endcase
        return v[15:0];
    endfunction

    function automatic logic [15:0] pick_gain();
        int v;
        case ($urandom_range(5))
            0: v = 0;
            1: v = 65535;
            2: v = 1;
            3: v = 2048;
            4: v = $urandom_range(255);
            default: v = $urandom;
        endcase
        return v[15:0];
    endfunction

    function automatic in_item_t random_req();
        in_item_t    r;
        int unsigned kind;
        kind = $urandom_range(99);
        if (kind < 30) begin
            r = odometry_req(pick_value(), pick_value());
        end else if (kind < 55) begin
            r = command_req(pick_value(), pick_value());
            // targets near the measured speed give small speed errors
            if ($urandom_range(2) == 0)
                r.target_speed = 16'(int'(speed_meas_q) + int'($urandom_range(1023)) - 512);
        end else if (kind < 95) begin
            r = noise_req(OP_TICK);
        end else begin
            r = noise_req(OP_UNUSED);
        end
        return r;
    endfunction

    task automatic send_request(in_item_t req);
        if (!steady && $urandom_range(99) < 9) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= req;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        absorb_request(req);
        n_requests++;
    endtask

    task automatic settle();
        s_valid <= 1'b0;
        while (expected_demands.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [15:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            CFG_STEER_LIMIT:   steer_limit_q = val;
            CFG_GAIN_THROTTLE: gain_thr_q    = val;
            CFG_GAIN_BRAKE:    gain_brk_q    = val;
            default: ;
        endcase
    endtask

    task automatic load_settings(logic [15:0] lim, logic [15:0] gt, logic [15:0] gb);
        settle();
        write_reg(CFG_STEER_LIMIT, lim);
        write_reg(CFG_GAIN_THROTTLE, gt);
        write_reg(CFG_GAIN_BRAKE, gb);
        // unmapped index must leave everything alone
        write_reg(CFG_NONE, pick_value());
        cfg_wr_en <= 1'b0;
        n_settings++;
    endtask

    task automatic test_before_command();
        send_request(noise_req(OP_TICK));
        send_request(odometry_req(16'd1000, 16'd0));
        send_request(noise_req(OP_TICK));
    endtask

    task automatic test_directed_cases();
        send_request(command_req(16'd2048, 16'd512));
        send_request(noise_req(OP_TICK));
        // magnitude above full scale saturates
        send_request(odometry_req(16'h7fff, 16'h7fff));
        send_request(noise_req(OP_TICK));
        // largest square sum, reversing
        send_request(odometry_req(16'h8000, 16'h8000));
        send_request(noise_req(OP_TICK));
        // lateral only stays positive
        send_request(odometry_req(16'd0, 16'h8000));
        send_request(command_req(16'h7fff, 16'h7fff));
        send_request(noise_req(OP_TICK));
        send_request(odometry_req(16'hffff, 16'd0));
        send_request(command_req(16'h8000, 16'd300));
        send_request(noise_req(OP_UNUSED));
        send_request(noise_req(OP_TICK));
        // zero speed error goes through the brake side
        send_request(command_req(16'hfffd, 16'hffff));
        send_request(noise_req(OP_TICK));
    endtask

    task automatic test_register_extremes();
        load_settings(16'd0, 16'hffff, 16'd0);
        send_request(command_req(16'd12345, 16'd100));
        send_request(odometry_req(16'd50, 16'd0));
        send_request(noise_req(OP_TICK));
        send_request(odometry_req(16'd200, 16'd0));
        send_request(noise_req(OP_TICK));
        load_settings(16'h8000, 16'd0, 16'hffff);
        send_request(command_req(16'h8000, 16'd0));
        send_request(noise_req(OP_TICK));
        load_settings(16'd3, 16'd1, 16'd1);
        // quotient truncates toward zero
        send_request(command_req(16'hffff, 16'd10));
        send_request(noise_req(OP_TICK));
        send_request(command_req(16'd7, 16'h8000));
        send_request(noise_req(OP_TICK));
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < 8; phase++) begin
            load_settings(pick_limit(), pick_gain(), pick_gain());
            steady = (phase == 5);
            for (int i = 0; i < 95; i++)
                send_request(random_req());
        end
        steady = 1'b0;
    endtask

    always @(posedge aclk) begin : result_check
        out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_demands.size() == 0) begin
                $error("unexpected result: steer_out %0d throttle_out %0d brake_out %0d",
                       m_data.steer_out, m_data.throttle_out, m_data.brake_out);
                n_errors++;
            end else begin
                want = expected_demands.pop_front();
                n_results++;
                if (m_data.steer_out !== want.steer_out) begin
                    $error("steer_out expected %0d actual %0d",
                           want.steer_out, m_data.steer_out);
                    n_errors++;
                end
                if (m_data.throttle_out !== want.throttle_out) begin
                    $error("throttle_out expected %0d actual %0d",
                           want.throttle_out, m_data.throttle_out);
                    n_errors++;
                end
                if (m_data.brake_out !== want.brake_out) begin
                    $error("brake_out expected %0d actual %0d",
                           want.brake_out, m_data.brake_out);
                    n_errors++;
                end
            end
        end
    end

    initial begin
        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_index     = CFG_NONE;
        cfg_wdata     = '0;
        s_valid       = 1'b0;
        s_data        = '0;
        steer_limit_q = SteerLimitRst;
        gain_thr_q    = GainThrottleRst;
        gain_brk_q    = GainBrakeRst;
        speed_meas_q  = '0;
        angle_cmd_q   = '0;
        speed_cmd_q   = '0;
        cmd_seen_q    = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        test_before_command();
        test_directed_cases();
        test_register_extremes();
        test_random_traffic();
        settle();

        $display("sent %0d requests, checked %0d results over %0d register settings",
                 n_requests, n_results, n_settings + 1);
        $display("included saturated speeds, clamped steering, zero limit and gain extremes");
        if (n_errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
